>>> design/baro_temp_pressure_compensation_macros.svh
// assertion macros for the compensation block checker
// used by btpc_checker only; no other dependencies
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// clocked assertion, masked while reset is high
`define BTPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BTPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/btpc_pkg.sv
// shared types and constants for the compensation block
// no dependencies
package btpc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_CAL_T1_T2 = 3'd0;
  localparam logic [2:0] REG_CAL_T3_P1 = 3'd1;
  localparam logic [2:0] REG_CAL_P2_P3 = 3'd2;
  localparam logic [2:0] REG_CAL_P4_P5 = 3'd3;
  localparam logic [2:0] REG_CAL_P6_P7 = 3'd4;
  localparam logic [2:0] REG_CAL_P8_P9 = 3'd5;

  localparam int RawW = 20;
  localparam int WordW = 32;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } item_t;

  // head of the input queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef struct packed {
    logic [WordW-1:0] t1_t2;
    logic [WordW-1:0] t3_p1;
    logic [WordW-1:0] p2_p3;
    logic [WordW-1:0] p4_p5;
    logic [WordW-1:0] p6_p7;
    logic [WordW-1:0] p8_p9;
  } cal_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic [63:0] sext16(input logic [15:0] x);
    sext16 = {{48{x[15]}}, x};
  endfunction

endpackage

>>> design/btpc_if.sv
// stream interfaces for raw samples and compensated results
// no dependencies
interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface btpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic        [31:0] pressure_pa;
  modport source (output valid, output temperature_centi, output pressure_pa, input ready);
  modport sink (input valid, input temperature_centi, input pressure_pa, output ready);
endinterface

>>> design/btpc_front.sv
// front end: accepts raw sample pairs into a two-entry queue
// depends on btpc_pkg and btpc_if
module btpc_front (
  input  logic          clk,
  input  logic          rst,
  btpc_in_if.sink       sample,
  output btpc_pkg::queue_t q,
  input  logic          pop
);
  import btpc_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign sample.ready = (count != 2'd2);
  assign push = sample.valid && sample.ready;
  assign q.valid = (count != 2'd0);
  assign q.item = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{raw_temperature: sample.raw_temperature,
                       raw_pressure: sample.raw_pressure};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

>>> design/btpc_div.sv
// signed 64-bit divider, one quotient bit per cycle, truncating toward zero
// depends on btpc_pkg
module btpc_div (
  input  logic                clk,
  input  logic                rst,
  input  btpc_pkg::div_req_t  req,
  output btpc_pkg::div_rsp_t  rsp
);
  import btpc_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIX  = 2'd2;

  logic [1:0]  state;
  logic [5:0]  cnt;
  logic        neg;
  logic [63:0] md;
  logic [63:0] rem;
  logic [63:0] dvd;
  logic [64:0] trial;
  logic        qbit;
  logic [63:0] quo;
  logic        done;

  // restoring step
  assign trial = {rem, dvd[63]};
  assign qbit = (trial >= {1'b0, md});

  assign rsp.done = done;
  assign rsp.quo = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done <= 1'b0;
    end else begin
      // done pulses for one cycle as the quotient is registered
      done <= (state == D_FIX);
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            neg <= req.num[63] ^ req.den[63];
            dvd <= req.num[63] ? (64'd0 - req.num) : req.num;
            md <= req.den[63] ? (64'd0 - req.den) : req.den;
            rem <= 64'd0;
            cnt <= 6'd0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= qbit ? 64'(trial - {1'b0, md}) : trial[63:0];
          dvd <= {dvd[62:0], qbit};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= D_FIX;
        end
        D_FIX: begin
          quo <= neg ? (64'd0 - dvd) : dvd;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

>>> design/btpc_back.sv
// back end: sequences the compensation over a shared 64x16 multiplier
// and the divider, and holds the result register
// depends on btpc_pkg and btpc_div
module btpc_back (
  input  logic               clk,
  input  logic               rst,
  input  btpc_pkg::cal_t     cal,
  input  btpc_pkg::queue_t   q,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] res_temp,
  output logic [31:0]        res_pres
);
  import btpc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_RND  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // multiply steps
  localparam logic [3:0] OP_V1   = 4'd0;
  localparam logic [3:0] OP_SQ   = 4'd1;
  localparam logic [3:0] OP_FINE = 4'd2;
  localparam logic [3:0] OP_TEMP = 4'd3;
  localparam logic [3:0] OP_XX   = 4'd4;
  localparam logic [3:0] OP_X2A  = 4'd5;
  localparam logic [3:0] OP_X2B  = 4'd6;
  localparam logic [3:0] OP_V1A  = 4'd7;
  localparam logic [3:0] OP_V1B  = 4'd8;
  localparam logic [3:0] OP_DEN  = 4'd9;
  localparam logic [3:0] OP_NUM  = 4'd10;
  localparam logic [3:0] OP_PS   = 4'd11;
  localparam logic [3:0] OP_Y1   = 4'd12;
  localparam logic [3:0] OP_Y2   = 4'd13;

  logic [2:0]  state;
  logic [3:0]  op;
  logic [1:0]  mcnt;
  logic [63:0] mul_a, mul_b, acc;
  logic [15:0] chunk;
  logic [63:0] part;
  logic [63:0] m;
  logic [19:0] adc_t, adc_p;
  logic [31:0] v1, fine, temp;
  logic [63:0] x1, xx, x2, var1, den, pv, y1, sum;
  logic [31:0] pres;
  logic [15:0] t1;
  logic [31:0] a_in, b_val, fine_new;
  logic [63:0] x1_new, var1_new, num0, sum_rnd;
  div_req_t    dreq;
  div_rsp_t    drsp;

  btpc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign t1 = cal.t1_t2[15:0];

  // one 64x16 partial product per cycle
  assign chunk = mul_b[{mcnt, 4'b0} +: 16];
  assign part = 64'(mul_a * {48'd0, chunk}) << {mcnt, 4'b0};
  assign m = acc + part;

  // operand preparation
  assign a_in = 32'({12'd0, q.item.raw_temperature} >> 3) - 32'({16'd0, t1} << 1);
  assign b_val = 32'({12'd0, adc_t} >> 4) - {16'd0, t1};
  assign fine_new = v1 + 32'($signed(m[31:0]) >>> 14);
  assign x1_new = {{32{fine[31]}}, fine} - 64'd128000;
  assign var1_new = var1 + (m << 12) + (64'd1 << 47);
  assign num0 = ((64'd1048576 - {44'd0, adc_p}) << 31) - x2;
  assign sum_rnd = sum + (sum[63] ? 64'd255 : 64'd0);

  assign pop = (state == ST_IDLE) && q.valid;
  assign dreq.start = (state == ST_MUL) && (mcnt == 2'd3) && (op == OP_NUM);
  assign dreq.num = m;
  assign dreq.den = den;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != ST_OUT)) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q.valid) begin
            adc_t <= q.item.raw_temperature;
            adc_p <= q.item.raw_pressure;
            mul_a <= {32'd0, a_in};
            mul_b <= sext16(cal.t1_t2[31:16]);
            acc <= 64'd0;
            mcnt <= 2'd0;
            op <= OP_V1;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mcnt != 2'd3) begin
            acc <= m;
            mcnt <= mcnt + 2'd1;
          end else begin
            acc <= 64'd0;
            mcnt <= 2'd0;
            op <= op + 4'd1;
            unique case (op)
              OP_V1: begin
                v1 <= 32'($signed(m[31:0]) >>> 11);
                mul_a <= {32'd0, b_val};
                mul_b <= {32'd0, b_val};
              end
              OP_SQ: begin
                mul_a <= {32'd0, 32'($signed(m[31:0]) >>> 12)};
                mul_b <= sext16(cal.t3_p1[15:0]);
              end
              OP_FINE: begin
                fine <= fine_new;
                mul_a <= {32'd0, fine_new};
                mul_b <= 64'd5;
              end
              OP_TEMP: begin
                temp <= 32'($signed(m[31:0] + 32'd128) >>> 8);
                x1 <= x1_new;
                mul_a <= x1_new;
                mul_b <= x1_new;
              end
              OP_XX: begin
                xx <= m;
                mul_a <= m;
                mul_b <= sext16(cal.p6_p7[15:0]);
              end
              OP_X2A: begin
                x2 <= m + (sext16(cal.p4_p5[15:0]) << 35);
                mul_a <= x1;
                mul_b <= sext16(cal.p4_p5[31:16]);
              end
              OP_X2B: begin
                x2 <= x2 + (m << 17);
                mul_a <= xx;
                mul_b <= sext16(cal.p2_p3[31:16]);
              end
              OP_V1A: begin
                var1 <= 64'($signed(m) >>> 8);
                mul_a <= x1;
                mul_b <= sext16(cal.p2_p3[15:0]);
              end
              OP_V1B: begin
                var1 <= var1_new;
                mul_a <= var1_new;
                mul_b <= {48'd0, cal.t3_p1[31:16]};
              end
              OP_DEN: begin
                den <= 64'($signed(m) >>> 33);
                mul_a <= num0;
                mul_b <= 64'd3125;
                if (64'($signed(m) >>> 33) == 64'd0) begin
                  pres <= 32'd0;
                  state <= ST_OUT;
                end
              end
              OP_NUM: begin
                state <= ST_DIV;
              end
              OP_PS: begin
                mul_a <= m;
                mul_b <= sext16(cal.p8_p9[31:16]);
              end
              OP_Y1: begin
                y1 <= 64'($signed(m) >>> 25);
                mul_a <= sext16(cal.p8_p9[15:0]);
                mul_b <= pv;
              end
              OP_Y2: begin
                sum <= pv + y1 + 64'($signed(m) >>> 19);
                state <= ST_FIN;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_DIV: begin
          if (drsp.done) begin
            pv <= drsp.quo;
            mul_a <= 64'($signed(drsp.quo) >>> 13);
            mul_b <= 64'($signed(drsp.quo) >>> 13);
            state <= ST_MUL;
          end
        end
        ST_FIN: begin
          sum <= 64'($signed(sum) >>> 8) + (sext16(cal.p6_p7[31:16]) << 4);
          state <= ST_RND;
        end
        ST_RND: begin
          // divide by 256 toward zero, low 32 bits
          pres <= sum_rnd[39:8];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            res_temp <= temp;
            res_pres <= pres;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/baro_temp_pressure_compensation.sv
// Barometric temperature and pressure compensation, 64-bit integer scheme.
// Channels: "sample" takes a raw temperature / raw pressure pair, "result"
// gives temperature in 0.01 degC and pressure in Pa; valid/ready handshake,
// a transaction moves when both are high. Calibration words are written over
// wr_en / wr_index / wr_data; the user must write them only while the block is
// idle, which the block itself does not enforce; indexes 6 and 7 are ignored.
// The back end handles one item at a time: fourteen products on a shared
// 64x16 multiplier, 64 steps in the bit-serial divider with its start and
// done hand-off, and the sequencing states in between.
// An item whose divisor is zero skips the divider and the later products.
// A two-entry input queue keeps taking samples while the back end computes,
// and the result register lets the next item proceed while a result waits.
// When the receiver stalls, the result is held and the back end waits at its
// final step; the input queue fills and then drops ready.
// Reset clears the queue, the sequencer, result valid and all calibration
// registers to zero.
// depends on btpc_pkg, btpc_if, btpc_front, btpc_back
module baro_temp_pressure_compensation (
  input  logic        clk,
  input  logic        rst,
  btpc_in_if.sink     sample,
  btpc_out_if.source  result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);
  import btpc_pkg::*;

  cal_t   cal;
  queue_t q;
  logic   pop;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CAL_T1_T2: cal.t1_t2 <= wr_data;
        REG_CAL_T3_P1: cal.t3_p1 <= wr_data;
        REG_CAL_P2_P3: cal.p2_p3 <= wr_data;
        REG_CAL_P4_P5: cal.p4_p5 <= wr_data;
        REG_CAL_P6_P7: cal.p6_p7 <= wr_data;
        REG_CAL_P8_P9: cal.p8_p9 <= wr_data;
        default: ;
      endcase
    end
  end

  btpc_front u_front (
    .clk(clk), .rst(rst), .sample(sample), .q(q), .pop(pop)
  );

  btpc_back u_back (
    .clk(clk), .rst(rst), .cal(cal), .q(q), .pop(pop),
    .res_valid(result.valid), .res_ready(result.ready),
    .res_temp(result.temperature_centi), .res_pres(result.pressure_pa)
  );

endmodule

>>> design/btpc_checker.sv
// port-level checker for the compensation block, bound to the top level
// depends on baro_temp_pressure_compensation_macros.svh
`include "baro_temp_pressure_compensation_macros.svh"

module btpc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_temp,
  input logic [31:0] out_pres
);

  logic [2:0] pending;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      if ((in_valid && in_ready) && !(out_valid && out_ready)) pending <= pending + 3'd1;
      else if (!(in_valid && in_ready) && (out_valid && out_ready)) pending <= pending - 3'd1;
    end
  end

  `BTPC_ASSERT_ALWAYS(a_reset_no_result, clk, rst |=> !out_valid, "result valid after reset")
  `BTPC_ASSERT(a_result_has_source, clk, rst, out_valid |-> (pending != 3'd0), "result with no pending sample")
  `BTPC_ASSERT(a_result_held, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(out_temp) && $stable(out_pres)), "stalled result changed")
  `BTPC_ASSERT(a_queue_bound, clk, rst, (pending >= 3'd4) |-> !in_ready, "more samples in flight than storage")

endmodule

bind baro_temp_pressure_compensation btpc_checker u_checker (
  .clk(clk), .rst(rst),
  .in_valid(sample.valid), .in_ready(sample.ready),
  .out_valid(result.valid), .out_ready(result.ready),
  .out_temp(result.temperature_centi), .out_pres(result.pressure_pa)
);

>>> sim/tb_baro_temp_pressure_compensation.sv
// self-checking testbench for baro_temp_pressure_compensation
// depends on btpc_pkg, btpc_if and the block itself
`timescale 1ns / 1ps

module tb_baro_temp_pressure_compensation;
  import btpc_pkg::*;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pa;
  } comp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = REG_CAL_T1_T2;
  logic [31:0] wr_data = '0;

  btpc_in_if sample ();
  btpc_out_if result ();

  baro_temp_pressure_compensation u_dut (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always #4 clk = ~clk;

  logic [31:0] cal_words [6];
  item_t       pending_samples [$];
  comp_t       expected_results [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off_cycles = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  longint      cycle_count = 0;

  initial begin
    sample.valid = 1'b0;
    sample.raw_temperature = '0;
    sample.raw_pressure = '0;
    result.ready = 1'b0;
  end

  // arithmetic shifts on raw vectors
  function automatic logic [31:0] asr32(logic [31:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  // signed divide truncating toward zero, wrapping on overflow
  function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  // compensated temperature and pressure for one raw pair
  function automatic comp_t compensate(item_t it);
    logic [31:0] adc_t, t1, t2, t3, a, v1, b, sq, v2, fine, temp;
    logic [63:0] adc_p, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] x1, x2, p, ps, y1, y2;
    comp_t r;
    adc_t = {12'd0, it.raw_temperature};
    adc_p = {44'd0, it.raw_pressure};
    t1 = {16'd0, cal_words[0][15:0]};
    t2 = {{16{cal_words[0][31]}}, cal_words[0][31:16]};
    t3 = {{16{cal_words[1][15]}}, cal_words[1][15:0]};
    p1 = {48'd0, cal_words[1][31:16]};
    p2 = sx16(cal_words[2][15:0]);  p3 = sx16(cal_words[2][31:16]);
    p4 = sx16(cal_words[3][15:0]);  p5 = sx16(cal_words[3][31:16]);
    p6 = sx16(cal_words[4][15:0]);  p7 = sx16(cal_words[4][31:16]);
    p8 = sx16(cal_words[5][15:0]);  p9 = sx16(cal_words[5][31:16]);
    // temperature path wraps at 32 bits
    a = (adc_t >> 3) - (t1 << 1);
    v1 = asr32(a * t2, 11);
    b = (adc_t >> 4) - t1;
    sq = asr32(b * b, 12);
    v2 = asr32(sq * t3, 14);
    fine = v1 + v2;
    temp = asr32(fine * 32'd5 + 32'd128, 8);
    // pressure path wraps at 64 bits
    x1 = {{32{fine[31]}}, fine} - 64'd128000;
    x2 = x1 * x1 * p6;
    x2 = x2 + ((x1 * p5) << 17);
    x2 = x2 + (p4 << 35);
    x1 = asr64(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
    x1 = asr64(((64'd1 << 47) + x1) * p1, 33);
    r.temperature_centi = temp;
    r.pressure_pa = '0;
    if (x1 != 0) begin
      p = 64'd1048576 - adc_p;
      p = div_trunc(((p << 31) - x2) * 64'd3125, x1);
      ps = asr64(p, 13);
      y1 = asr64(p9 * ps * ps, 25);
      y2 = asr64(p8 * p, 19);
      p = asr64(p + y1 + y2, 8) + (p7 << 4);
      p = div_trunc(p, 64'd256);
      r.pressure_pa = p[31:0];
    end
    return r;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample.valid <= 1'b0;
    end else if (!sample.valid || sample.ready) begin
      if (sample.valid) begin
        expected_results.push_back(compensate({sample.raw_temperature,
                                                sample.raw_pressure}));
      end
      if (pending_samples.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        item_t it;
        it = pending_samples.pop_front();
        sample.valid <= 1'b1;
        sample.raw_temperature <= it.raw_temperature;
        sample.raw_pressure <= it.raw_pressure;
      end else begin
        sample.valid <= 1'b0;
      end
    end
  end

  // long receiver stall, counted down on its own
  always @(posedge clk) begin
    if (hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result transaction");
        end else begin
          comp_t e;
          e = expected_results.pop_front();
          if (e.temperature_centi !== result.temperature_centi ||
              e.pressure_pa !== result.pressure_pa) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp t=%0d p=%0d got t=%0d p=%0d",
                       $signed(e.temperature_centi), e.pressure_pa,
                       result.temperature_centi, result.pressure_pa);
          end
        end
      end
      if (hold_off_cycles > 0) begin
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    if (cycle_count > 64'd2500000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_cal(int idx, logic [31:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx[2:0];
    wr_data <= val;
    cal_words[idx] = val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // wait until the block has drained, then some latency margin
  task automatic drain();
    while (pending_samples.size() > 0 || sample.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic load_typical();
    write_cal(0, {16'd26435, 16'd27504});
    write_cal(1, {16'd36477, 16'hFC18});
    write_cal(2, {16'd3024, 16'hD6D0});
    write_cal(3, {16'd140, 16'd2855});
    write_cal(4, {16'd15500, 16'hFFF9});
    write_cal(5, {16'd6000, 16'hC001});
  endtask

  task automatic load_random();
    for (int i = 0; i < 6; i++) write_cal(i, $urandom());
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      item_t it;
      if ($urandom_range(3, 0) != 0) begin
        it.raw_temperature = 20'(32'd519888 + $urandom_range(200000, 0) - 32'd100000);
        it.raw_pressure = 20'(32'd415148 + $urandom_range(200000, 0) - 32'd100000);
      end else begin
        it.raw_temperature = 20'($urandom());
        it.raw_pressure = 20'($urandom());
      end
      pending_samples.push_back(it);
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) cal_words[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero calibration gives a zero divisor
    pending_samples.push_back({20'd0, 20'd0});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF});
    drain();

    // directed: field extremes with typical calibration
    load_typical();
    pending_samples.push_back({20'd0, 20'd0});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF});
    pending_samples.push_back({20'd0, 20'hFFFFF});
    pending_samples.push_back({20'hFFFFF, 20'd0});
    pending_samples.push_back({20'd519888, 20'd415148});
    pending_samples.push_back({20'h55555, 20'hAAAAA});
    pending_samples.push_back({20'hAAAAA, 20'h55555});
    drain();

    // extreme calibration words
    for (int i = 0; i < 6; i++) write_cal(i, 32'hFFFFFFFF);
    pending_samples.push_back({20'd0, 20'd0});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF});
    pending_samples.push_back({20'd519888, 20'd415148});
    drain();
    for (int i = 0; i < 6; i++) write_cal(i, 32'h80008000);
    pending_samples.push_back({20'd0, 20'hFFFFF});
    pending_samples.push_back({20'hFFFFF, 20'd0});
    pending_samples.push_back({20'd519888, 20'd415148});
    drain();
    for (int i = 0; i < 6; i++) write_cal(i, 32'h7FFF7FFF);
    pending_samples.push_back({20'd0, 20'd0});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF});
    drain();

    // random phase 1: sender sparse idle, receiver heavy idle
    send_idle_pct = 6; recv_idle_pct = 60;
    load_typical();
    push_random(200);
    hold_off_cycles = 3000;
    drain();
    load_random();
    push_random(180);
    drain();

    // random phase 2: roles swapped
    send_idle_pct = 60; recv_idle_pct = 6;
    load_random();
    push_random(180);
    drain();
    load_typical();
    push_random(180);
    drain();

    // random phase 3: no idling
    send_idle_pct = 0; recv_idle_pct = 0;
    load_random();
    push_random(200);
    drain();
    load_typical();
    push_random(190);
    drain();

    $display("covered %0d results over zero, extreme, typical and random calibrations",
             results_seen);
    $display("idle mixes: sender/receiver 6/60, 60/6 and none, with a long receiver stall");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
